FILE: src/ssqm_pkg.sv
`timescale 1ns / 1ps

package ssqm_pkg;

    // fixed field widths of the ports
    localparam int SVC_W  = 10;
    localparam int WAIT_W = 16;
    localparam int QLEN_W = 7;
    localparam int CNT_W  = 20;
    localparam int SUM_W  = 32;

    // requests from the server logic to the stamp queue
    typedef struct packed {
        logic push_req;   // accepted tick carries an arrival
        logic pop;        // server takes the oldest stamp
    } q_ctrl_t;

    // queue status seen by the server logic
    typedef struct packed {
        logic full;       // arrival of this tick gets dropped
        logic has_item;   // at least one stamp after this tick's push
    } q_stat_t;

endpackage

FILE: src/single_server_queue_monitor_unit.sv
`timescale 1ns / 1ps
// a tick accepted at a clock edge has its result registered onto the m_ ports at that same edge
// throughput: one tick per cycle while the result is taken, set by the single registered update of queue and server
// the result holds until taken; a new tick is accepted in the cycle the result is taken
// reset (aresetn low, synchronous): queue empty, server free, tick and statistics zero,
// service_time back to 1; the stamp ring itself is not cleared

module single_server_queue_monitor_unit #(
    parameter int QUEUE_DEPTH = 64,
    parameter int TICK_BITS   = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // tick input
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_arrival,
    // configuration write
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ssqm_pkg::SVC_W-1:0]  cfg_service_time,
    // result output
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_served,
    output logic [ssqm_pkg::WAIT_W-1:0] m_served_wait,
    output logic [ssqm_pkg::QLEN_W-1:0] m_queue_length,
    output logic                        m_server_busy,
    output logic [ssqm_pkg::CNT_W-1:0]  m_served_count,
    output logic [ssqm_pkg::WAIT_W-1:0] m_max_wait,
    output logic [ssqm_pkg::SUM_W-1:0]  m_total_wait,
    output logic [ssqm_pkg::SUM_W-1:0]  m_total_service,
    output logic                        m_dropped
);
    import ssqm_pkg::*;

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic                   accept;
    q_ctrl_t                q_ctrl;
    q_stat_t                q_stat;
    logic [TICK_BITS-1:0]   head_stamp;
    logic [OCC_W-1:0]       occupancy;

    logic [SVC_W-1:0]       svc_reg;
    logic [SVC_W-1:0]       svc_eff;
    logic [TICK_BITS-1:0]   tick_reg, tick_next;
    logic [TICK_BITS-1:0]   finish_reg, finish_next;
    logic                   busy_reg, busy_next;
    logic                   busy_held;
    logic                   pop;

    logic [TICK_BITS-1:0]   wait_raw;
    logic [TICK_BITS+15:0]  wait_wide;
    logic [WAIT_W-1:0]      wait_sat;
    logic [TICK_BITS+9:0]   finish_sum;
    logic [OCC_W+6:0]       occ_wide;

    logic                   m_valid_reg;
    logic                   served_reg;
    logic [WAIT_W-1:0]      wait_reg;
    logic                   dropped_reg;

    // output slot frees when empty or being taken
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // service time register, zero acts as one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            svc_reg <= SVC_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            svc_reg <= cfg_service_time;
        end
    end
    assign svc_eff = (svc_reg == '0) ? SVC_W'(1) : svc_reg;

    // push request, then release at finish, then pop into a free server
    assign q_ctrl.push_req = accept && s_arrival;
    assign busy_held       = busy_reg && (tick_reg != finish_reg);
    assign pop             = accept && !busy_held && q_stat.has_item;
    assign q_ctrl.pop      = pop;

    ssqm_stamp_queue #(
        .DEPTH  (QUEUE_DEPTH),
        .TICK_W (TICK_BITS),
        .PTR_W  (PTR_W),
        .OCC_W  (OCC_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (q_ctrl),
        .tick_now   (tick_reg),
        .stat       (q_stat),
        .head_stamp (head_stamp),
        .occupancy  (occupancy)
    );

    // wait modulo the tick width, clipped to the field
    assign wait_raw  = tick_reg - head_stamp;
    assign wait_wide = {16'd0, wait_raw};
    assign wait_sat  = (|wait_wide[TICK_BITS+15:WAIT_W]) ? '1 : wait_wide[WAIT_W-1:0];

    assign finish_sum = {10'd0, tick_reg} + {{TICK_BITS{1'b0}}, svc_eff};

    // server state and tick counter
    always_comb begin
        tick_next   = tick_reg;
        finish_next = finish_reg;
        busy_next   = busy_reg;
        if (accept) begin
            tick_next = tick_reg + 1'b1;
            busy_next = busy_held || pop;
            if (pop) begin
                finish_next = finish_sum[TICK_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg   <= '0;
            finish_reg <= '0;
            busy_reg   <= 1'b0;
        end else begin
            tick_reg   <= tick_next;
            finish_reg <= finish_next;
            busy_reg   <= busy_next;
        end
    end

    ssqm_stats u_stats (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pop           (pop),
        .wait_ticks    (wait_sat),
        .svc_ticks     (svc_eff),
        .served_count  (m_served_count),
        .max_wait      (m_max_wait),
        .total_wait    (m_total_wait),
        .total_service (m_total_service)
    );

    // per-tick result fields
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (accept) begin
            served_reg  <= pop;
            wait_reg    <= pop ? wait_sat : '0;
            dropped_reg <= s_arrival && q_stat.full;
        end
    end

    // state registers only move on a transfer, so they hold with the result
    assign occ_wide       = {7'd0, occupancy};
    assign m_valid        = m_valid_reg;
    assign m_served       = served_reg;
    assign m_served_wait  = wait_reg;
    assign m_queue_length = occ_wide[QLEN_W-1:0];
    assign m_server_busy  = busy_reg;
    assign m_dropped      = dropped_reg;

endmodule

FILE: src/ssqm_stamp_queue.sv
`timescale 1ns / 1ps

module ssqm_stamp_queue #(
    parameter int DEPTH  = 64,
    parameter int TICK_W = 16,
    parameter int PTR_W  = $clog2(DEPTH),
    parameter int OCC_W  = $clog2(DEPTH + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ssqm_pkg::q_ctrl_t    ctrl,
    input  logic [TICK_W-1:0]    tick_now,
    output ssqm_pkg::q_stat_t    stat,
    output logic [TICK_W-1:0]    head_stamp,
    output logic [OCC_W-1:0]     occupancy
);
    import ssqm_pkg::*;

    logic [TICK_W-1:0] stamp_mem [DEPTH];
    logic [TICK_W-1:0] rd_data_reg;
    logic [TICK_W-1:0] byp_data_reg;
    logic              byp_valid_reg;

    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [OCC_W-1:0]  occ_reg, occ_next, occ_push;
    logic              push;

    // push unless the ring is full
    assign stat.full     = (occ_reg == OCC_W'(DEPTH));
    assign push          = ctrl.push_req && !stat.full;
    assign occ_push      = occ_reg + OCC_W'(push);
    assign stat.has_item = (occ_push != '0);

    // an empty queue hands over the stamp being pushed this tick
    always_comb begin
        if (occ_reg == '0) begin
            head_stamp = tick_now;
        end else if (byp_valid_reg) begin
            head_stamp = byp_data_reg;
        end else begin
            head_stamp = rd_data_reg;
        end
    end

    // pointer and occupancy update with wrap at the ring end
    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (ctrl.pop) begin
            head_next = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (push) begin
            tail_next = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        occ_next = occ_push - OCC_W'(ctrl.pop);
    end

    assign occupancy = occ_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            occ_reg  <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            occ_reg  <= occ_next;
        end
    end

    // stamp ring: one write, one registered read at the next head
    always_ff @(posedge aclk) begin
        if (push) begin
            stamp_mem[tail_reg] <= tick_now;
        end
        rd_data_reg <= stamp_mem[head_next];
    end

    // write to the address being read returns old data, so hold the new stamp
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_valid_reg <= 1'b0;
        end else begin
            byp_valid_reg <= push && (tail_reg == head_next);
        end
        byp_data_reg <= tick_now;
    end

endmodule

FILE: src/ssqm_stats.sv
`timescale 1ns / 1ps

module ssqm_stats (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        pop,
    input  logic [ssqm_pkg::WAIT_W-1:0] wait_ticks,
    input  logic [ssqm_pkg::SVC_W-1:0]  svc_ticks,
    output logic [ssqm_pkg::CNT_W-1:0]  served_count,
    output logic [ssqm_pkg::WAIT_W-1:0] max_wait,
    output logic [ssqm_pkg::SUM_W-1:0]  total_wait,
    output logic [ssqm_pkg::SUM_W-1:0]  total_service
);
    import ssqm_pkg::*;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [WAIT_W-1:0] max_reg, max_next;
    logic [SUM_W-1:0]  wsum_reg, wsum_next;
    logic [SUM_W-1:0]  ssum_reg, ssum_next;
    logic [SUM_W:0]    wsum_add, ssum_add;

    assign wsum_add = {1'b0, wsum_reg} + {{(SUM_W + 1 - WAIT_W){1'b0}}, wait_ticks};
    assign ssum_add = {1'b0, ssum_reg} + {{(SUM_W + 1 - SVC_W){1'b0}}, svc_ticks};

    // saturating accumulators, updated on each service start
    always_comb begin
        count_next = count_reg;
        max_next   = max_reg;
        wsum_next  = wsum_reg;
        ssum_next  = ssum_reg;
        if (pop) begin
            count_next = (&count_reg) ? count_reg : count_reg + 1'b1;
            max_next   = (wait_ticks > max_reg) ? wait_ticks : max_reg;
            wsum_next  = wsum_add[SUM_W] ? '1 : wsum_add[SUM_W-1:0];
            ssum_next  = ssum_add[SUM_W] ? '1 : ssum_add[SUM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            max_reg   <= '0;
            wsum_reg  <= '0;
            ssum_reg  <= '0;
        end else begin
            count_reg <= count_next;
            max_reg   <= max_next;
            wsum_reg  <= wsum_next;
            ssum_reg  <= ssum_next;
        end
    end

    assign served_count  = count_reg;
    assign max_wait      = max_reg;
    assign total_wait    = wsum_reg;
    assign total_service = ssum_reg;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import ssqm_pkg::*;

    localparam int RING_DEPTH = 64;
    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER = 600;

    // one tick's statistics as seen on the result channel
    typedef struct packed {
        logic              served;
        logic [WAIT_W-1:0] served_wait;
        logic [QLEN_W-1:0] queue_length;
        logic              server_busy;
        logic [CNT_W-1:0]  served_count;
        logic [WAIT_W-1:0] max_wait;
        logic [SUM_W-1:0]  total_wait;
        logic [SUM_W-1:0]  total_service;
        logic              dropped;
    } tick_stats_t;

    typedef enum logic [0:0] {ROW_TICK, ROW_CFG} row_kind_e;

    // one line of the directed plan
    typedef struct packed {
        row_kind_e        kind;
        logic             arrival;
        logic [7:0]       reps;
        logic [SVC_W-1:0] svc;
        logic             typed;
        tick_stats_t      want;
    } plan_row_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic                s_arrival;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [SVC_W-1:0]    cfg_service_time;
    logic                m_valid;
    logic                m_ready;
    logic                m_served;
    logic [WAIT_W-1:0]   m_served_wait;
    logic [QLEN_W-1:0]   m_queue_length;
    logic                m_server_busy;
    logic [CNT_W-1:0]    m_served_count;
    logic [WAIT_W-1:0]   m_max_wait;
    logic [SUM_W-1:0]    m_total_wait;
    logic [SUM_W-1:0]    m_total_service;
    logic                m_dropped;

    single_server_queue_monitor_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_arrival        (s_arrival),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_service_time (cfg_service_time),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_served         (m_served),
        .m_served_wait    (m_served_wait),
        .m_queue_length   (m_queue_length),
        .m_server_busy    (m_server_busy),
        .m_served_count   (m_served_count),
        .m_max_wait       (m_max_wait),
        .m_total_wait     (m_total_wait),
        .m_total_service  (m_total_service),
        .m_dropped        (m_dropped)
    );

    // queue and server state mirrored by the predictor
    logic [WAIT_W-1:0] ring_stamp [RING_DEPTH];
    logic [5:0]        ring_head;
    logic [5:0]        ring_tail;
    logic [QLEN_W-1:0] ring_fill;
    logic [WAIT_W-1:0] tick_cnt;
    logic              server_on;
    logic [WAIT_W-1:0] finish_at;
    logic [CNT_W-1:0]  served_total;
    logic [WAIT_W-1:0] wait_peak;
    logic [SUM_W-1:0]  wait_total;
    logic [SUM_W-1:0]  service_total;
    logic [SVC_W-1:0]  svc_ticks;

    tick_stats_t expected_ticks[$];
    plan_row_t   plan[$];
    int          mismatches = 0;
    int          results_seen = 0;
    bit          gaps_on = 1'b1;

    // clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [SUM_W-1:0] add_sat(input logic [SUM_W-1:0] a,
                                                  input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    // one tick: push, release, pop, then advance the tick counter
    function automatic tick_stats_t next_tick_stats(input logic arr);
        tick_stats_t       r;
        logic [WAIT_W-1:0] w;
        logic [SVC_W-1:0]  st;
        r = '0;
        if (arr) begin
            if (ring_fill >= RING_DEPTH) begin
                r.dropped = 1'b1;
            end else begin
                ring_stamp[ring_tail] = tick_cnt;
                ring_tail = ring_tail + 1'b1;
                ring_fill = ring_fill + 1'b1;
            end
        end
        if (server_on && tick_cnt == finish_at)
            server_on = 1'b0;
        if (!server_on && ring_fill != 0) begin
            st = (svc_ticks == 0) ? SVC_W'(1) : svc_ticks;
            w = tick_cnt - ring_stamp[ring_head];
            ring_head = ring_head + 1'b1;
            ring_fill = ring_fill - 1'b1;
            if (w > wait_peak)
                wait_peak = w;
            wait_total = add_sat(wait_total, SUM_W'(w));
            service_total = add_sat(service_total, SUM_W'(st));
            finish_at = tick_cnt + WAIT_W'(st);
            if (served_total != {CNT_W{1'b1}})
                served_total = served_total + 1'b1;
            server_on = 1'b1;
            r.served = 1'b1;
            r.served_wait = w;
        end
        tick_cnt = tick_cnt + 1'b1;
        r.queue_length = ring_fill;
        r.server_busy = server_on;
        r.served_count = served_total;
        r.max_wait = wait_peak;
        r.total_wait = wait_total;
        r.total_service = service_total;
        return r;
    endfunction

    // offer one tick, wait for its transfer, then log what it should produce
    task automatic drive_tick(input logic arr, input logic typed, input tick_stats_t want);
        tick_stats_t pred;
        if (gaps_on) begin
            while ($urandom_range(99) < 32) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_arrival <= arr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = next_tick_stats(arr);
        expected_ticks.push_back(typed ? want : pred);
    endtask

    // service time is only rewritten once every tick result is back
    task automatic write_service(input logic [SVC_W-1:0] val);
        s_valid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_service_time <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        svc_ticks = val;
    endtask

    task automatic add_row(input row_kind_e kind, input logic arr, input int reps,
                           input logic [SVC_W-1:0] svc, input logic typed,
                           input tick_stats_t want);
        plan_row_t row;
        row.kind = kind;
        row.arrival = arr;
        row.reps = reps[7:0];
        row.svc = svc;
        row.typed = typed;
        row.want = want;
        plan.push_back(row);
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch expected %0d actual %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    // result side: compare each transfer, then pick ready for the next cycle
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    always @(posedge aclk) begin
        tick_stats_t e;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_ticks.size() == 0) begin
                $display("%0t: result transfer with nothing expected", $time);
                mismatches++;
            end else begin
                e = expected_ticks.pop_front();
                check_field("served", e.served, m_served);
                check_field("served_wait", e.served_wait, m_served_wait);
                check_field("queue_length", e.queue_length, m_queue_length);
                check_field("server_busy", e.server_busy, m_server_busy);
                check_field("served_count", e.served_count, m_served_count);
                check_field("max_wait", e.max_wait, m_max_wait);
                check_field("total_wait", e.total_wait, m_total_wait);
                check_field("total_service", e.total_service, m_total_service);
                check_field("dropped", e.dropped, m_dropped);
            end
        end
        // one long hold-off so the block fills and stalls its input
        if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!gaps_on) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= 32);
        end
    end

    // watchdog on cycles without any transfer
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("single_server_queue_monitor_unit test failed");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        int          arrive_pct [7];
        logic [SVC_W-1:0] svc;
        tick_stats_t none;
        tick_stats_t first_idle;
        tick_stats_t first_serve;

        arrive_pct = '{50, 95, 30, 70, 100, 20, 60};
        none = '0;
        first_idle = '0;
        first_serve = '0;
        first_serve.served = 1'b1;
        first_serve.server_busy = 1'b1;
        first_serve.served_count = CNT_W'(1);
        first_serve.total_service = SUM_W'(1);

        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_arrival <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_service_time <= '0;
        m_ready <= 1'b0;

        ring_head = '0;
        ring_tail = '0;
        ring_fill = '0;
        tick_cnt = '0;
        server_on = 1'b0;
        finish_at = '0;
        served_total = '0;
        wait_peak = '0;
        wait_total = '0;
        service_total = '0;
        svc_ticks = SVC_W'(1);

        // directed plan: reset values, same-tick service, zero and longest
        // service times, a full queue with drops, then a drain
        add_row(ROW_TICK, 1'b0, 1, '0, 1'b1, first_idle);
        add_row(ROW_TICK, 1'b1, 1, '0, 1'b1, first_serve);
        add_row(ROW_TICK, 1'b1, 1, '0, 1'b0, none);
        add_row(ROW_TICK, 1'b1, 2, '0, 1'b0, none);
        add_row(ROW_TICK, 1'b0, 2, '0, 1'b0, none);
        add_row(ROW_CFG,  1'b0, 0, SVC_W'(0), 1'b0, none);
        add_row(ROW_TICK, 1'b1, 3, '0, 1'b0, none);
        add_row(ROW_TICK, 1'b0, 1, '0, 1'b0, none);
        add_row(ROW_CFG,  1'b0, 0, {SVC_W{1'b1}}, 1'b0, none);
        add_row(ROW_TICK, 1'b1, 68, '0, 1'b0, none);
        add_row(ROW_TICK, 1'b0, 2, '0, 1'b0, none);
        add_row(ROW_CFG,  1'b0, 0, SVC_W'(1), 1'b0, none);
        add_row(ROW_TICK, 1'b0, 8, '0, 1'b0, none);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                write_service(plan[i].svc);
            end else begin
                repeat (plan[i].reps) drive_tick(plan[i].arrival, plan[i].typed, plan[i].want);
            end
        end

        // random phases, each with its own service time and arrival rate
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: svc = SVC_W'(2);
                1: svc = {SVC_W{1'b1}};
                2: svc = '0;
                3: svc = SVC_W'($urandom_range(1, 16));
                4: svc = SVC_W'(1);
                5: svc = SVC_W'($urandom_range(0, 1023));
                default: svc = {SVC_W{1'b1}};
            endcase
            write_service(svc);
            gaps_on = (ph != 3);
            repeat (250) drive_tick($urandom_range(99) < arrive_pct[ph], 1'b0, none);
        end
        gaps_on = 1'b1;
        s_valid <= 1'b0;

        // drain, then a few quiet cycles for stray results
        while (expected_ticks.size() != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
        if (mismatches == 0 && expected_ticks.size() == 0) begin
            $display("single_server_queue_monitor_unit test passed");
        end else begin
            $display("single_server_queue_monitor_unit test failed");
        end
        $finish;
    end

endmodule
